/* rtl/core/ecm_pkg.sv */
// ecm_pkg: shared types, codes and hash helpers for the edge coverage map
// used by ecm_ctrl, ecm_datapath, edge_coverage_hash_map and ecm_checker; depends on nothing
`timescale 1ns / 1ps

package ecm_pkg;

    // map geometry default
    localparam int MAP_ADDR_BITS_DEF = 16;

    // fnv-1a constants
    localparam logic [31:0] FNV_BASIS = 32'h811C_9DC5;
    localparam logic [31:0] FNV_PRIME = 32'h0100_0193;

    // item kind codes
    localparam logic [1:0] KIND_PATH = 2'd0;
    localparam logic [1:0] KIND_LINE = 2'd1;
    localparam logic [1:0] KIND_READ = 2'd2;

    // result kind codes
    localparam logic RES_EDGE = 1'b0;
    localparam logic RES_READ = 1'b1;

    // input word
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  path_byte;
        logic [31:0] line_number;
        logic [15:0] read_index;
    } in_word_t;

    // output word
    typedef struct packed {
        logic        result_kind;
        logic [15:0] map_index;
        logic [7:0]  hit_count;
    } out_word_t;

    // controller to datapath commands
    typedef struct packed {
        logic clr_write;
        logic path_fold;
        logic line_load;
        logic read_issue;
        logic hash_step;
        logic edge_issue;
        logic finish_load;
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic clr_last;
        logic line_zero;
        logic out_free;
    } status_t;

    // one fnv-1a byte fold, product kept modulo 2^32
    function automatic logic [31:0] fnv_fold(input logic [31:0] h, input logic [7:0] b);
        logic [31:0] x;
        x = h ^ {24'd0, b};
        return x * FNV_PRIME;
    endfunction

endpackage

/* rtl/core/ecm_ram.sv */
// ecm_ram: generic single write port, single read port ram with registered read
// depends on nothing
`timescale 1ns / 1ps

module ecm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/core/ecm_ctrl.sv */
// ecm_ctrl: sequencer for clearing, hashing, counter updates and map reads
// depends on ecm_pkg
`timescale 1ns / 1ps

module ecm_ctrl
    import ecm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    input  logic [1:0] item_kind,
    input  status_t status,
    output logic    item_stall,
    output cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_CLEAR  = 4'b0001,
        ST_IDLE   = 4'b0010,
        ST_HASH   = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    // input taken only while idle
    assign item_stall = (state_reg != ST_IDLE);
    assign accept     = item_valid && (state_reg == ST_IDLE);

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_write = 1'b1;
                if (status.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (item_kind)
                        KIND_PATH:
                        begin
                            cmd.path_fold = 1'b1;
                        end
                        KIND_LINE:
                        begin
                            cmd.line_load = 1'b1;
                            state_next    = ST_HASH;
                        end
                        KIND_READ:
                        begin
                            cmd.read_issue = 1'b1;
                            state_next     = ST_FINISH;
                        end
                        default:
                        begin
                            // unused kind is dropped
                        end
                    endcase
                end
            end
            ST_HASH:
            begin
                if (!status.line_zero)
                begin
                    cmd.hash_step = 1'b1;
                end
                else
                begin
                    cmd.edge_issue = 1'b1;
                    state_next     = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.finish_load = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* rtl/core/ecm_datapath.sv */
// ecm_datapath: hash register, line shifter, edge index logic, counter map, output word
// depends on ecm_pkg and ecm_ram
`timescale 1ns / 1ps

module ecm_datapath
    import ecm_pkg::*;
#(
    parameter int MAP_ADDR_BITS = MAP_ADDR_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    input  in_word_t  item,
    input  cmd_t      cmd,
    output status_t   status,
    output logic      result_valid,
    input  logic      result_stall,
    output out_word_t result
);

    localparam int DEPTH = 1 << MAP_ADDR_BITS;

    logic [31:0]              hash_reg, hash_next;
    logic [31:0]              line_reg, line_next;
    logic [MAP_ADDR_BITS-1:0] prev_reg, prev_next;
    logic [MAP_ADDR_BITS-1:0] idx_reg, idx_next;
    logic [MAP_ADDR_BITS-1:0] clr_addr_reg, clr_addr_next;
    logic                     mode_read_reg, mode_read_next;
    logic                     out_valid_reg, out_valid_next;
    out_word_t                out_word_reg, out_word_next;

    logic [MAP_ADDR_BITS-1:0] loc;
    logic [MAP_ADDR_BITS-1:0] edge_idx;
    logic                     ram_we;
    logic [MAP_ADDR_BITS-1:0] ram_waddr;
    logic [7:0]               ram_wdata;
    logic                     ram_re;
    logic [MAP_ADDR_BITS-1:0] ram_raddr;
    logic [7:0]               ram_rdata;
    logic [7:0]               count_inc;

    // location and edge index from the finished hash
    assign loc       = hash_reg[MAP_ADDR_BITS-1:0];
    assign edge_idx  = loc ^ prev_reg;
    assign count_inc = ram_rdata + 8'd1;

    // status back to the controller
    assign status.clr_last  = (clr_addr_reg == '1);
    assign status.line_zero = (line_reg == 32'd0);
    assign status.out_free  = !out_valid_reg || !result_stall;

    // counter map ports
    assign ram_we    = cmd.clr_write || (cmd.finish_load && !mode_read_reg);
    assign ram_waddr = cmd.clr_write ? clr_addr_reg : idx_reg;
    assign ram_wdata = cmd.clr_write ? 8'd0 : count_inc;
    assign ram_re    = cmd.read_issue || cmd.edge_issue;
    assign ram_raddr = cmd.read_issue ? MAP_ADDR_BITS'(item.read_index) : edge_idx;

    ecm_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_map (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // hash, line and index updates
    always_comb
    begin
        hash_next      = hash_reg;
        line_next      = line_reg;
        prev_next      = prev_reg;
        idx_next       = idx_reg;
        mode_read_next = mode_read_reg;
        clr_addr_next  = clr_addr_reg;
        if (cmd.clr_write)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
        end
        if (cmd.path_fold)
        begin
            hash_next = fnv_fold(hash_reg, item.path_byte);
        end
        if (cmd.line_load)
        begin
            line_next = item.line_number;
        end
        if (cmd.hash_step)
        begin
            hash_next = fnv_fold(hash_reg, line_reg[7:0]);
            line_next = line_reg >> 8;
        end
        if (cmd.edge_issue)
        begin
            hash_next      = FNV_BASIS;
            prev_next      = loc >> 1;
            idx_next       = edge_idx;
            mode_read_next = 1'b0;
        end
        if (cmd.read_issue)
        begin
            idx_next       = MAP_ADDR_BITS'(item.read_index);
            mode_read_next = 1'b1;
        end
    end

    // output word staging
    always_comb
    begin
        out_word_next  = out_word_reg;
        out_valid_next = out_valid_reg && result_stall;
        if (cmd.finish_load)
        begin
            out_valid_next            = 1'b1;
            out_word_next.result_kind = mode_read_reg ? RES_READ : RES_EDGE;
            out_word_next.map_index   = 16'(idx_reg);
            out_word_next.hit_count   = mode_read_reg ? ram_rdata : count_inc;
        end
    end

    // control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg      <= FNV_BASIS;
            prev_reg      <= '0;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            hash_reg      <= hash_next;
            prev_reg      <= prev_next;
            clr_addr_reg  <= clr_addr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        line_reg      <= line_next;
        idx_reg       <= idx_next;
        mode_read_reg <= mode_read_next;
        out_word_reg  <= out_word_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_word_reg;

endmodule

/* rtl/core/edge_coverage_hash_map.sv */
// channel  dir  handshake                      word
// item     in   item_valid / item_stall        in_word_t (kind, path_byte, line_number, read_index)
// result   out  result_valid / result_stall    out_word_t (result_kind, map_index, hit_count)
//
// path byte: one fnv multiply in the hash register, the block stays idle for the next word
// line event: folds line bytes from the low end up to the highest nonzero byte (0 to 4), one multiply per byte,
//   then a read-modify-write of the counter ram
// read: a registered ram read at read_index, then the finish step loads the result word
// after reset a clearing pass writes zero to all 2^MAP_ADDR_BITS map entries with item_stall high
// a stalled result holds the finish step until the output register frees
//
// edge_coverage_hash_map: top level, controller plus datapath
// depends on ecm_pkg, ecm_ctrl, ecm_datapath
`timescale 1ns / 1ps

module edge_coverage_hash_map
    import ecm_pkg::*;
#(
    parameter int MAP_ADDR_BITS = MAP_ADDR_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    output logic      item_stall,
    input  in_word_t  item,
    output logic      result_valid,
    input  logic      result_stall,
    output out_word_t result
);

    cmd_t    cmd;
    status_t status;

    // sequencer
    ecm_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_kind  (item.kind),
        .status     (status),
        .item_stall (item_stall),
        .cmd        (cmd)
    );

    // datapath and counter map
    ecm_datapath #(
        .MAP_ADDR_BITS (MAP_ADDR_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .status       (status),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

/* rtl/core/ecm_checker.sv */
// ecm_checker: port level assertions for the edge coverage map, bound to the top level
// depends on ecm_pkg and edge_coverage_hash_map
`timescale 1ns / 1ps

module ecm_checker
    import ecm_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      item_valid,
    input logic      item_stall,
    input in_word_t  item,
    input logic      result_valid,
    input logic      result_stall,
    input out_word_t result
);

    // stalled result word stays valid
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
    else $error("result dropped while stalled");

    // stalled result word holds its value
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> $stable(result))
    else $error("result changed while stalled");

    // a path byte never produces a result right after it
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall && item.kind == KIND_PATH |=> !$rose(result_valid))
    else $error("result raised after path byte");

    // line and read words keep the block busy on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall && (item.kind == KIND_LINE || item.kind == KIND_READ)
        |=> item_stall)
    else $error("new word taken while line or read in progress");

endmodule

bind edge_coverage_hash_map ecm_checker u_ecm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);
